// File: hdl/sfdg_pkg.sv
// Shared constants and types for the servo feedback deframer guard.
package sfdg_pkg;

    // Frame layout
    localparam int MOTOR_COUNT = 7;
    localparam int MOTOR_W     = 3;
    localparam int ROW_W       = 48;

    localparam logic [7:0] HDR_FIRST  = 8'h86;
    localparam logic [7:0] HDR_SECOND = 8'hC2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TORQUE_TRIP    = 2'd0;
    localparam logic [1:0] CFG_TORQUE_RELEASE = 2'd1;
    localparam logic [1:0] CFG_POS_UPPER      = 2'd2;
    localparam logic [1:0] CFG_POS_LOWER      = 2'd3;

    // Configuration reset values
    localparam logic [15:0]        TRIP_RESET      = 16'd1500;
    localparam logic [15:0]        REL_RESET       = 16'd50;
    localparam logic signed [15:0] POS_UPPER_RESET = 16'sd8;
    localparam logic signed [15:0] POS_LOWER_RESET = -16'sd2888;

    typedef logic [MOTOR_W-1:0] t_motor;

    typedef struct packed {
        logic [15:0]        trip_level;
        logic [15:0]        rel_level;
        logic signed [15:0] pos_upper;
        logic signed [15:0] pos_lower;
    } t_guard_cfg;

endpackage

// File: hdl/servo_feedback_deframer_guard_core.sv
// Top level: byte deframer, double-banked motor rows and result drain.
//
// Input channel: one stream byte per beat on i_rx_byte (i_valid / o_ready).
// Bytes are dropped until the header 0x86 0xC2; the next 2 + 6*MOTOR_COUNT
// bytes carry status, mode and per motor big-endian position, velocity and
// torque. A byte is taken every cycle while o_ready is high.
// Output channel (o_valid / i_ready): after the last byte of a frame, one
// beat per motor, motor 0 first, last_of_frame set on the gripper beat. The
// first result becomes valid once the final byte has set the drain flag and
// the first row is loaded into the output register; the rest follow one per
// cycle while the receiver takes them.
// Motor rows are kept in two banks, so the next frame fills one bank while
// the previous one drains from the other. o_ready drops only when the final
// byte of a frame arrives while the prior frame has not finished draining;
// otherwise a receiver stall never holds up the byte stream.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata);
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (synchronous, active low) returns to header hunting, clears both
// safety flags, empties the output and loads the default thresholds.
module servo_feedback_deframer_guard_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_motor_index,
    output logic [7:0]           o_arm_status,
    output logic [7:0]           o_arm_mode,
    output logic signed [15:0]   o_position_milli,
    output logic signed [15:0]   o_velocity_milli,
    output logic signed [15:0]   o_torque_milli,
    output logic                 o_torque_fault,
    output logic                 o_position_fault,
    output logic                 o_last_of_frame,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [15:0]          i_cfg_wdata
);

    // Deframer phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HALF = 3'd1;
    localparam logic [2:0] PH_STAT = 3'd2;
    localparam logic [2:0] PH_MODE = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam sfdg_pkg::t_motor LAST_MOTOR =
        sfdg_pkg::t_motor'(sfdg_pkg::MOTOR_COUNT - 1);

    // Configuration
    sfdg_pkg::t_guard_cfg r_cfg;

    // Deframer state
    logic [2:0]        r_phase;
    logic [2:0]        n_phase;
    sfdg_pkg::t_motor  r_motor;
    sfdg_pkg::t_motor  n_motor;
    logic [2:0]        r_off;
    logic [2:0]        n_off;
    logic [39:0]       r_acc;
    logic              r_wbank;
    logic              r_rbank;

    // Frame storage, two banks
    logic [sfdg_pkg::ROW_W-1:0] r_rows [0:1][0:sfdg_pkg::MOTOR_COUNT-1];
    logic [7:0]                 r_status [0:1];
    logic [7:0]                 r_mode   [0:1];

    // Drain state
    logic              r_draining;
    sfdg_pkg::t_motor  r_drain_idx;
    logic              r_out_valid;

    logic              in_fire;
    logic              final_byte;
    logic              frame_done;
    logic              row_wr;
    logic              out_load;
    logic              drain_last;
    logic              guard_torque_fault;
    logic              guard_position_fault;
    logic [sfdg_pkg::ROW_W-1:0] row_rd;

    assign final_byte = (r_phase == PH_DATA) && (r_motor == LAST_MOTOR) && (r_off == 3'd5);
    assign o_ready    = !(r_draining && final_byte);
    assign in_fire    = i_valid && o_ready;
    assign frame_done = in_fire && final_byte;
    assign row_wr     = in_fire && (r_phase == PH_DATA) && (r_off == 3'd5);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trip_level <= sfdg_pkg::TRIP_RESET;
            r_cfg.rel_level  <= sfdg_pkg::REL_RESET;
            r_cfg.pos_upper  <= sfdg_pkg::POS_UPPER_RESET;
            r_cfg.pos_lower  <= sfdg_pkg::POS_LOWER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sfdg_pkg::CFG_TORQUE_TRIP:    r_cfg.trip_level <= i_cfg_wdata;
                sfdg_pkg::CFG_TORQUE_RELEASE: r_cfg.rel_level  <= i_cfg_wdata;
                sfdg_pkg::CFG_POS_UPPER:      r_cfg.pos_upper  <= $signed(i_cfg_wdata);
                sfdg_pkg::CFG_POS_LOWER:      r_cfg.pos_lower  <= $signed(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // Header hunt and byte position tracking
    always_comb begin
        n_phase = r_phase;
        n_motor = r_motor;
        n_off   = r_off;
        case (r_phase)
            PH_HUNT: begin
                n_phase = (i_rx_byte == sfdg_pkg::HDR_FIRST) ? PH_HALF : PH_HUNT;
            end
            PH_HALF: begin
                if (i_rx_byte == sfdg_pkg::HDR_SECOND) begin
                    n_phase = PH_STAT;
                end else if (i_rx_byte != sfdg_pkg::HDR_FIRST) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_STAT: begin
                n_phase = PH_MODE;
            end
            PH_MODE: begin
                n_phase = PH_DATA;
                n_motor = '0;
                n_off   = 3'd0;
            end
            PH_DATA: begin
                if (r_off == 3'd5) begin
                    n_off = 3'd0;
                    if (r_motor == LAST_MOTOR) begin
                        n_phase = PH_HUNT;
                        n_motor = '0;
                    end else begin
                        n_motor = r_motor + 1'b1;
                    end
                end else begin
                    n_off = r_off + 3'd1;
                end
            end
            default: begin
                n_phase = (i_rx_byte == sfdg_pkg::HDR_FIRST) ? PH_HALF : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_motor <= '0;
            r_off   <= 3'd0;
            r_wbank <= 1'b0;
            r_rbank <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_motor <= n_motor;
            r_off   <= n_off;
            // Flip banks at frame end; drain the one just filled
            if (final_byte) begin
                r_wbank <= ~r_wbank;
                r_rbank <= r_wbank;
            end
        end
    end

    // Assemble row bytes and store status, mode and completed rows
    always_ff @(posedge i_clk) begin
        if (in_fire && (r_phase == PH_DATA)) begin
            r_acc <= {r_acc[31:0], i_rx_byte};
        end
        if (in_fire && (r_phase == PH_STAT)) begin
            r_status[r_wbank] <= i_rx_byte;
        end
        if (in_fire && (r_phase == PH_MODE)) begin
            r_mode[r_wbank] <= i_rx_byte;
        end
        if (row_wr) begin
            r_rows[r_wbank][r_motor] <= {r_acc, i_rx_byte};
        end
    end

    // Gripper flags, updated on the final byte
    sfdg_guard u_guard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_update         (frame_done),
        .i_gpos           ($signed(r_acc[39:24])),
        .i_gtor           ($signed({r_acc[7:0], i_rx_byte})),
        .o_torque_fault   (guard_torque_fault),
        .o_position_fault (guard_position_fault)
    );

    // Drain one motor per beat into the output register
    assign out_load   = r_draining && (!r_out_valid || i_ready);
    assign drain_last = (r_drain_idx == LAST_MOTOR);
    assign row_rd     = r_rows[r_rbank][r_drain_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining  <= 1'b0;
            r_drain_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (frame_done) begin
                r_draining  <= 1'b1;
                r_drain_idx <= '0;
            end else if (out_load) begin
                if (drain_last) begin
                    r_draining  <= 1'b0;
                    r_drain_idx <= '0;
                end else begin
                    r_drain_idx <= r_drain_idx + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload, no reset; flags travel with the beat they belong to
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_motor_index    <= r_drain_idx;
            o_arm_status     <= r_status[r_rbank];
            o_arm_mode       <= r_mode[r_rbank];
            o_position_milli <= $signed(row_rd[47:32]);
            o_velocity_milli <= $signed(row_rd[31:16]);
            o_torque_milli   <= $signed(row_rd[15:0]);
            o_torque_fault   <= guard_torque_fault;
            o_position_fault <= guard_position_fault;
            o_last_of_frame  <= drain_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: hdl/sfdg_guard.sv
// Gripper safety flags: torque hysteresis and position window check.
module sfdg_guard (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sfdg_pkg::t_guard_cfg    i_cfg,
    input  logic                    i_update,
    input  logic signed [15:0]      i_gpos,
    input  logic signed [15:0]      i_gtor,
    output logic                    o_torque_fault,
    output logic                    o_position_fault
);

    logic [16:0] tor_ext;
    logic [16:0] tor_mag;
    logic        trip_hit;
    logic        rel_hit;
    logic        n_torque_flag;
    logic        n_position_flag;
    logic        r_torque_flag;
    logic        r_position_flag;

    // Magnitude of gripper torque, one bit wider so -32768 fits
    assign tor_ext  = {i_gtor[15], i_gtor};
    assign tor_mag  = i_gtor[15] ? (~tor_ext + 17'd1) : tor_ext;
    assign trip_hit = tor_mag > {1'b0, i_cfg.trip_level};
    assign rel_hit  = tor_mag < {1'b0, i_cfg.rel_level};

    // Setting wins over clearing; between the levels hold
    always_comb begin
        n_torque_flag = r_torque_flag;
        if (trip_hit) begin
            n_torque_flag = 1'b1;
        end else if (rel_hit) begin
            n_torque_flag = 1'b0;
        end
        n_position_flag = (i_gpos > i_cfg.pos_upper) || (i_gpos < i_cfg.pos_lower);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_flag   <= 1'b0;
            r_position_flag <= 1'b0;
        end else if (i_update) begin
            r_torque_flag   <= n_torque_flag;
            r_position_flag <= n_position_flag;
        end
    end

    assign o_torque_fault   = r_torque_flag;
    assign o_position_fault = r_position_flag;

endmodule
